>>> rtl/gf256_reed_solomon_encoder_assert.svh
// Assertion macros shared by the encoder's checker.
`ifndef GF256_REED_SOLOMON_ENCODER_ASSERT_SVH
`define GF256_REED_SOLOMON_ENCODER_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define RSENC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define RSENC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rsenc_pkg.sv
// Types, constants and GF(256) arithmetic for the Reed-Solomon encoder.
package rsenc_pkg;

    typedef logic [7:0] gf_elem_t;
    typedef logic [4:0] cfg_count_t;

    // Low byte of the field polynomial x^8+x^4+x^3+x^2+1
    localparam gf_elem_t   FIELD_LOW    = 8'h1d;
    localparam cfg_count_t RESET_PARITY = 5'd10;
    localparam int         QUEUE_DEPTH  = 2;

    // One data item as it travels from the front to the back
    typedef struct packed {
        gf_elem_t data_byte;
        logic     block_end;
    } item_t;

    // Head of the item queue as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    // Generator builder status
    typedef struct packed {
        logic busy;
        logic restart;
    } gen_status_t;

    // Multiply by alpha
    function automatic gf_elem_t gf_xtime(gf_elem_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? FIELD_LOW : 8'h00);
    endfunction

    // Full GF(256) product, shift and add over the bits of b
    function automatic gf_elem_t gf_mul(gf_elem_t a, gf_elem_t b);
        gf_elem_t p;
        gf_elem_t x;
        p = '0;
        x = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                p = p ^ x;
            end
            x = gf_xtime(x);
        end
        return p;
    endfunction

endpackage

>>> rtl/rsenc_if.sv
// Channel interfaces of the Reed-Solomon encoder.
interface rsenc_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] parity_count;

    modport source (output valid, output parity_count, input ready);
    modport sink (input valid, input parity_count, output ready);
endinterface

interface rsenc_data_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_end;

    modport source (output valid, output data_byte, output block_end, input ready);
    modport sink (input valid, input data_byte, input block_end, output ready);
endinterface

interface rsenc_parity_if;
    logic       valid;
    logic       ready;
    logic [7:0] parity_byte;
    logic       parity_last;

    modport source (output valid, output parity_byte, output parity_last, input ready);
    modport sink (input valid, input parity_byte, input parity_last, output ready);
endinterface

>>> rtl/rsenc_gen.sv
// Generator polynomial builder: one root factor multiplied in per cycle.
module rsenc_gen
    import rsenc_pkg::*;
#(
    parameter int MAX_PARITY = 30
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_fire,
    input  cfg_count_t                         cfg_value,
    output logic [$clog2(MAX_PARITY+1)-1:0]    count,
    output gf_elem_t                           coeff [MAX_PARITY],
    output gen_status_t                        status
);

    localparam int CW         = $clog2(MAX_PARITY + 1);
    localparam int ResetCount = (int'(RESET_PARITY) > MAX_PARITY) ? MAX_PARITY
                                                                   : int'(RESET_PARITY);

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] step_reg, step_next;
    gf_elem_t      root_reg, root_next;
    gf_elem_t      poly_reg [MAX_PARITY];
    gf_elem_t      poly_next [MAX_PARITY];
    gf_elem_t      poly_step [MAX_PARITY];
    logic [CW-1:0] clamped;
    logic          busy;

    // Saturate the written count into 1..MAX_PARITY
    always_comb
    begin
        if (cfg_value == '0)
        begin
            clamped = CW'(1);
        end
        else if (int'(cfg_value) > MAX_PARITY)
        begin
            clamped = CW'(MAX_PARITY);
        end
        else
        begin
            clamped = CW'(cfg_value);
        end
    end

    assign busy = (step_reg < count_reg);

    // Multiply the current polynomial by (x + root)
    always_comb
    begin
        poly_step[0] = gf_mul(poly_reg[0], root_reg);
        for (int j = 1; j < MAX_PARITY; j++)
        begin
            poly_step[j] = poly_reg[j-1] ^ gf_mul(poly_reg[j], root_reg);
        end
    end

    // Restart on a write, advance one factor per cycle while busy
    always_comb
    begin
        count_next = count_reg;
        step_next  = step_reg;
        root_next  = root_reg;
        poly_next  = poly_reg;
        if (cfg_fire)
        begin
            count_next = clamped;
            step_next  = '0;
            root_next  = 8'h01;
            for (int j = 0; j < MAX_PARITY; j++)
            begin
                poly_next[j] = (j == 0) ? 8'h01 : 8'h00;
            end
        end
        else if (busy)
        begin
            step_next = step_reg + CW'(1);
            root_next = gf_xtime(root_reg);
            poly_next = poly_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(ResetCount);
            step_reg  <= '0;
            root_reg  <= 8'h01;
            for (int j = 0; j < MAX_PARITY; j++)
            begin
                poly_reg[j] <= (j == 0) ? 8'h01 : 8'h00;
            end
        end
        else
        begin
            count_reg <= count_next;
            step_reg  <= step_next;
            root_reg  <= root_next;
            poly_reg  <= poly_next;
        end
    end

    assign count          = count_reg;
    assign coeff          = poly_reg;
    assign status.busy    = busy;
    assign status.restart = cfg_fire;

endmodule

>>> rtl/rsenc_front.sv
// Front end: accept data items into a short queue.
module rsenc_front
    import rsenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  gen_status_t status,
    input  logic        in_valid,
    input  item_t       in_item,
    output logic        in_ready,
    output queue_head_t head,
    input  logic        pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    item_t         mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          push;

    // Hold off items while the generator is rebuilt or the queue is full
    assign in_ready = !status.busy && (fill_reg != FW'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the accepted item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign head.valid = (fill_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

endmodule

>>> rtl/rsenc_back.sv
// Back end: remainder LFSR and parity output shifter.
module rsenc_back
    import rsenc_pkg::*;
#(
    parameter int MAX_PARITY = 30
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  gen_status_t                        status,
    input  logic [$clog2(MAX_PARITY+1)-1:0]    count,
    input  gf_elem_t                           coeff [MAX_PARITY],
    input  queue_head_t                        head,
    output logic                               pop,
    input  logic                               out_ready,
    output logic                               out_valid,
    output gf_elem_t                           out_byte,
    output logic                               out_last
);

    localparam int CW = $clog2(MAX_PARITY + 1);
    localparam int IW = $clog2(MAX_PARITY);

    gf_elem_t      rem_reg [MAX_PARITY];
    gf_elem_t      rem_next [MAX_PARITY];
    gf_elem_t      rem_upd [MAX_PARITY];
    gf_elem_t      sh_reg [MAX_PARITY];
    gf_elem_t      sh_next [MAX_PARITY];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] top_idx;
    gf_elem_t      fb;
    logic          out_fire;
    logic          sh_free;

    assign top_idx  = IW'(count - CW'(1));
    assign out_fire = out_valid && out_ready;
    assign sh_free  = (cnt_reg == '0) || ((cnt_reg == CW'(1)) && out_ready);

    // Take the next item unless the generator is busy or its parity would collide with the current drain
    assign pop = head.valid && !status.busy && (!head.item.block_end || sh_free);

    // One LFSR step: feedback times each generator tap
    assign fb = head.item.data_byte ^ rem_reg[top_idx];
    always_comb
    begin
        rem_upd[0] = gf_mul(fb, coeff[0]);
        for (int k = 1; k < MAX_PARITY; k++)
        begin
            rem_upd[k] = rem_reg[k-1] ^ gf_mul(fb, coeff[k]);
        end
    end

    // Update remainder, load or shift parity, count the drain
    always_comb
    begin
        rem_next = rem_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (out_fire)
        begin
            sh_next[0] = 8'h00;
            for (int k = 1; k < MAX_PARITY; k++)
            begin
                sh_next[k] = sh_reg[k-1];
            end
            cnt_next = cnt_reg - CW'(1);
        end
        if (status.restart)
        begin
            for (int k = 0; k < MAX_PARITY; k++)
            begin
                rem_next[k] = 8'h00;
            end
            cnt_next = '0;
        end
        else if (pop)
        begin
            if (head.item.block_end)
            begin
                for (int k = 0; k < MAX_PARITY; k++)
                begin
                    rem_next[k] = 8'h00;
                end
                sh_next  = rem_upd;
                cnt_next = count;
            end
            else
            begin
                rem_next = rem_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PARITY; k++)
            begin
                rem_reg[k] <= 8'h00;
            end
            cnt_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
        end
    end

    // Parity payload needs no reset
    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    assign out_valid = (cnt_reg != '0);
    assign out_byte  = sh_reg[top_idx];
    assign out_last  = (cnt_reg == CW'(1));

endmodule

>>> rtl/gf256_reed_solomon_encoder.sv
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D, roots
// alpha^0..alpha^(n-1). Data bytes stream in highest degree first at one byte per clock
// while the generator is idle and the queue has room; they pass through a two-entry
// queue into a parallel LFSR that does all n GF multiplies in the same cycle. On a byte
// flagged block_end the n parity bytes are emitted from an output shifter, one per cycle
// while parity ready is high, highest degree first, the last one flagged; data of the
// next block keeps flowing meanwhile, the shifter being the only limit when blocks are
// shorter than n. Writing parity_count (0 reads as 1, values above MAX_PARITY saturate)
// clears the remainder and rebuilds the generator, one root factor per cycle: data ready
// stays low while it rebuilds, after each write and likewise after reset.
module gf256_reed_solomon_encoder
    import rsenc_pkg::*;
#(
    parameter int MAX_PARITY = 30
)
(
    input  logic           clk,
    input  logic           rst_n,
    rsenc_cfg_if.sink      cfg,
    rsenc_data_if.sink     data,
    rsenc_parity_if.source parity
);

    localparam int CW = $clog2(MAX_PARITY + 1);

    logic [CW-1:0] count;
    gf_elem_t      coeff [MAX_PARITY];
    gen_status_t   status;
    queue_head_t   head;
    item_t         in_item;
    logic          in_ready;
    logic          pop;

    // Configuration is always taken
    assign cfg.ready = 1'b1;

    rsenc_gen #(
        .MAX_PARITY (MAX_PARITY)
    ) u_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_fire  (cfg.valid && cfg.ready),
        .cfg_value (cfg.parity_count),
        .count     (count),
        .coeff     (coeff),
        .status    (status)
    );

    assign in_item.data_byte = data.data_byte;
    assign in_item.block_end = data.block_end;
    assign data.ready        = in_ready;

    rsenc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .in_valid (data.valid),
        .in_item  (in_item),
        .in_ready (in_ready),
        .head     (head),
        .pop      (pop)
    );

    rsenc_back #(
        .MAX_PARITY (MAX_PARITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .count     (count),
        .coeff     (coeff),
        .head      (head),
        .pop       (pop),
        .out_ready (parity.ready),
        .out_valid (parity.valid),
        .out_byte  (parity.parity_byte),
        .out_last  (parity.parity_last)
    );

endmodule

>>> rtl/rsenc_checker.sv
// Port-level checker for the encoder and its bind.
`include "gf256_reed_solomon_encoder_assert.svh"

module rsenc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_block_end,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    logic [2:0] pend_reg, pend_next;
    logic       blk_in;
    logic       blk_out;

    // Count blocks whose parity is still owed
    assign blk_in  = in_valid && in_ready && in_block_end;
    assign blk_out = out_valid && out_ready && out_last;

    always_comb
    begin
        pend_next = pend_reg;
        if (blk_in && !blk_out)
        begin
            pend_next = pend_reg + 3'd1;
        end
        else if (blk_out && !blk_in)
        begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `RSENC_ASSERT_NEXT(a_parity_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last), "parity item changed while stalled")
    `RSENC_ASSERT_SAME(a_parity_owed, out_valid, pend_reg != 3'd0, "parity shown with no block end pending")
    `RSENC_ASSERT_SAME(a_pend_bound, blk_in, pend_reg < 3'd3, "block end accepted beyond queue and shifter")
    `RSENC_ASSERT_NEXT(a_cfg_rebuild, cfg_valid && cfg_ready, !in_ready, "data taken while generator rebuilds")

endmodule

bind gf256_reed_solomon_encoder rsenc_checker u_rsenc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .in_valid     (data.valid),
    .in_ready     (data.ready),
    .in_block_end (data.block_end),
    .out_valid    (parity.valid),
    .out_ready    (parity.ready),
    .out_byte     (parity.parity_byte),
    .out_last     (parity.parity_last)
);
